[design/deq_pkg.sv]
// shared types and constants for the double-ended queue block
// no dependencies; imported by double_ended_queue_top and deq_checker
package deq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KIND_W   = 3;
    localparam int VAL_W    = 64;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 2 * VAL_W + 1 + FILL_W + STATUS_W;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_REVERSE    = 3'd4,
        K_QUERY      = 3'd5
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [CNT_W-1:0]    count;
        logic                rev;
        logic                byp_first;
        logic                byp_last;
        logic [DATA_W-1:0]   wdata;
    } t_meta;

endpackage

[design/deq_ram.sv]
// generic simple ram: one write port, two read ports with registered read data
// no dependencies
module deq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[design/double_ended_queue_top.sv]
// double-ended queue top level: ring store, head/count/reverse state, output stage
// depends on deq_pkg and deq_ram
//
// slave stream takes one operation per beat: tuser carries the kind
// (push front, push back, pop front, pop back, reverse, query), tdata the
// word to push. master stream returns one result beat per operation with
// the logical front and back words, empty flag, element count and status
// (done, push rejected when full, pop rejected when empty).
// each operation passes the input register, the state update with the
// ring store write and its two registered reads (front and back slot),
// then the output register.
// one operation per cycle while the master side does not stall; the state
// update and the ring store access for one operation happen in the same cycle.
// reset empties the queue (head, count and reverse flag cleared) and
// drops all beats in flight; store contents are not cleared.
// when the master side stalls, each stage holds and fills in turn;
// s_axis_tready drops only once every stage holds a beat.
module double_ended_queue_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [deq_pkg::VAL_W-1:0]     s_axis_tdata,  // push_value
    input  logic [deq_pkg::KIND_W-1:0]    s_axis_tuser,  // kind
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [deq_pkg::OUT_W-1:0]     m_axis_tdata   // front_value, back_value,
                                                         // is_empty, fill_count, status
);
    import deq_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(idx) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic en1, en2, en3;

    logic               r1_valid;
    t_kind              r1_kind;
    logic [DATA_W-1:0]  r1_value;

    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_rev, n_rev;
    t_status            n_status;
    logic               n_we;
    logic [IDX_W-1:0]   n_waddr;
    logic [IDX_W-1:0]   raddr_first, raddr_last;

    logic               r2_valid;
    t_meta              r2_meta, n_meta;
    logic [DATA_W-1:0]  rd_first, rd_last;

    logic               r3_valid;
    logic [VAL_W-1:0]   r3_front, r3_back;
    logic               r3_empty;
    logic [FILL_W-1:0]  r3_count;
    t_status            r3_status;
    logic [DATA_W-1:0]  first_val, last_val;

    // stage enables, each stage fills when the one after it stalls
    assign en3 = !r3_valid || m_axis_tready;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= s_axis_tvalid;
        end
        if (en1 && s_axis_tvalid) begin
            r1_kind  <= t_kind'(s_axis_tuser);
            r1_value <= s_axis_tdata[DATA_W-1:0];
        end
    end

    // next state of the ring for the operation in stage one
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_rev    = r_rev;
        n_status = ST_DONE;
        n_we     = 1'b0;
        n_waddr  = ring_add(r_head, r_count);
        case (r1_kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
                if (r_count == CNT_FULL) begin
                    n_status = ST_FULL;
                end else begin
                    n_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    if ((r1_kind == K_PUSH_FRONT) != r_rev) begin
                        n_head  = (r_head == '0) ? IDX_LAST : r_head - 1'b1;
                        n_waddr = n_head;
                    end
                end
            end
            K_POP_FRONT, K_POP_BACK: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                    if ((r1_kind == K_POP_FRONT) != r_rev) begin
                        n_head = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;
                    end
                end
            end
            K_REVERSE: begin
                n_rev = !r_rev;
            end
            default: begin
            end
        endcase
    end

    assign raddr_first = n_head;
    assign raddr_last  = ring_add(n_head, n_count - 1'b1);

    always_comb begin
        n_meta.status    = n_status;
        n_meta.count     = n_count;
        n_meta.rev       = n_rev;
        n_meta.byp_first = n_we && (n_waddr == raddr_first);
        n_meta.byp_last  = n_we && (n_waddr == raddr_last);
        n_meta.wdata     = r1_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_rev    <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (en2 && r1_valid) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_rev   <= n_rev;
            end
            if (en2) begin
                r2_valid <= r1_valid;
            end
        end
        if (en2) begin
            r2_meta <= n_meta;
        end
    end

    deq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (en2 && r1_valid && n_we),
        .i_waddr   (n_waddr),
        .i_wdata   (r1_value),
        .i_re      (en2),
        .i_raddr_a (raddr_first),
        .i_raddr_b (raddr_last),
        .o_rdata_a (rd_first),
        .o_rdata_b (rd_last)
    );

    // write-through for a slot written in the same cycle it was read
    always_comb begin
        first_val = r2_meta.byp_first ? r2_meta.wdata : rd_first;
        last_val  = r2_meta.byp_last  ? r2_meta.wdata : rd_last;
        if (r2_meta.count == '0) begin
            first_val = '0;
            last_val  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
        if (en3) begin
            r3_front  <= VAL_W'(r2_meta.rev ? last_val : first_val);
            r3_back   <= VAL_W'(r2_meta.rev ? first_val : last_val);
            r3_empty  <= (r2_meta.count == '0);
            r3_count  <= FILL_W'(r2_meta.count);
            r3_status <= r2_meta.status;
        end
    end

    assign m_axis_tvalid = r3_valid;
    assign m_axis_tdata  = {r3_status, r3_count, r3_empty, r3_back, r3_front};

endmodule

[design/deq_checker.sv]
// port-level checks on the double-ended queue result stream
// depends on deq_pkg; bound to double_ended_queue_top
module deq_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_m_tvalid,
    input  logic [deq_pkg::OUT_W-1:0]     i_m_tdata
);
    import deq_pkg::*;

    logic [VAL_W-1:0]    front_value;
    logic [VAL_W-1:0]    back_value;
    logic                is_empty;
    logic [FILL_W-1:0]   fill_count;
    logic [STATUS_W-1:0] status;

    assign front_value = i_m_tdata[VAL_W-1:0];
    assign back_value  = i_m_tdata[2*VAL_W-1:VAL_W];
    assign is_empty    = i_m_tdata[2*VAL_W];
    assign fill_count  = i_m_tdata[2*VAL_W+FILL_W:2*VAL_W+1];
    assign status      = i_m_tdata[OUT_W-1:OUT_W-STATUS_W];

    a_no_beat_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result beat right after reset");

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (is_empty == (fill_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_zero_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && is_empty) |-> (front_value == '0 && back_value == '0))
        else $error("nonzero values on empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (fill_count <= FILL_W'(CAPACITY)))
        else $error("count above capacity");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && status == ST_FULL) |-> (fill_count == FILL_W'(CAPACITY)))
        else $error("push rejected while not full");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tdata  (m_axis_tdata)
);
